### rtl/dsvr_pkg.sv
package dsvr_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned GroupSize   = 32;
  localparam int unsigned MidPerGroup = 30;
  localparam int unsigned IdW         = 10;
  localparam int unsigned CntW        = 11;
  localparam int unsigned KeyW        = 17;
  localparam int unsigned DegW        = 16;
  localparam int unsigned SlotW       = 5;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 2;

  typedef enum logic [1:0] {
    KeyIn  = 2'd0,
    KeyOut = 2'd1,
    KeySum = 2'd2,
    KeyAlt = 2'd3
  } sort_key_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSortKey = 1'b0,
    CfgScatter = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StSortV,
    StSortU,
    StSortDrain,
    StSortWr,
    StLabel,
    StLabelDrain
  } state_e;

  localparam logic [SlotW-1:0] SlotHead    = SlotW'(0);
  localparam logic [SlotW-1:0] SlotTail    = SlotW'(1);
  localparam logic [SlotW-1:0] SlotMidLast = SlotW'(MidPerGroup + 1);

endpackage

### rtl/degree_sort_vertex_relabel.sv
// degree sort vertex relabeler
// input channel (in_valid_i / in_ready_o) carries two kinds of beat. a vertex
// beat (kind 0) gives the out- and in-degree of the next vertex in id order;
// its key (chosen by sort_key) goes to the key memory. the beat marked
// last_vertex starts labeling: every vertex is ranked by a sweep over all n
// keys, then the ranking (optionally warp interleaved) is turned into labels.
// no input beat is taken while labeling runs; a vertex beat after labeling
// starts a new graph. an edge beat (kind 1) reads both labels from the label
// memory into registers, then the result register gives one result beat on
// the output channel; the next input beat is taken once that result has left,
// so no new edge is taken while the last is in flight. a stalled receiver
// holds the result and the input side waits. bad_vertex flags an endpoint not
// below the loaded count, or any edge before labels exist. reset clears the
// count and the labels-ready flag; memory contents need no clearing. the user
// writes configuration through cfg_we_i only at idle time (the block does not
// enforce this); it takes effect on the next vertex beat or labeling pass.
module degree_sort_vertex_relabel (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dsvr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dsvr_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic [dsvr_pkg::DegW-1:0]         out_count_i,
  input  logic [dsvr_pkg::DegW-1:0]         in_count_i,
  input  logic                              last_vertex_i,
  input  logic [dsvr_pkg::IdW-1:0]          src_id_i,
  input  logic [dsvr_pkg::IdW-1:0]          dst_id_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dsvr_pkg::IdW-1:0]          new_src_o,
  output logic [dsvr_pkg::IdW-1:0]          new_dst_o,
  output logic                              bad_vertex_o
);

  localparam int unsigned IdW  = dsvr_pkg::IdW;
  localparam int unsigned CntW = dsvr_pkg::CntW;
  localparam int unsigned KeyW = dsvr_pkg::KeyW;
  localparam int unsigned Depth = dsvr_pkg::MaxVertices;

  logic [KeyW-1:0] key_mem   [Depth];
  logic [IdW-1:0]  rank_mem  [Depth];
  logic [IdW-1:0]  label_mem [Depth];

  dsvr_pkg::state_e state_q, state_d;
  dsvr_pkg::sort_key_e sort_key_q;
  logic scatter_q;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ready_q, ready_d;
  logic [CntW-1:0] v_q, v_d, u_q, u_d, ud_q, r_q, r_d;
  logic            p_q;
  logic [CntW-1:0] pos_q, pos_d, pd_q, gi_q, gi_d, mo_q, mo_d;
  logic [dsvr_pkg::SlotW-1:0] sl_q, sl_d;
  logic            emit_q;
  logic            pend_q, s_ok_q, d_ok_q;
  logic            out_valid_q;
  logic [IdW-1:0]  new_src_q, new_dst_q;
  logic            bad_q;

  logic [KeyW-1:0] key_a, key_b, key_new;
  logic [IdW-1:0]  rank_rd, lab_s, lab_d;

  logic            in_fire, vtx_fire, edge_fire;
  logic [CntW-1:0] cnt_eff;
  logic            key_we;
  logic            issue_u, last_u, gt;
  logic [CntW-1:0] w_grp, mid_n, rank_idx;
  logic [CntW+1:0] n_up;
  logic            emit, last_emit, scat;

  assign in_fire   = in_valid_i && in_ready_o;
  assign vtx_fire  = in_fire && !kind_i;
  assign edge_fire = in_fire && kind_i;
  assign cnt_eff   = ready_q ? '0 : cnt_q;
  assign key_we    = vtx_fire && (cnt_eff < CntW'(Depth));

  always_comb begin
    case (sort_key_q)
      dsvr_pkg::KeyIn:  key_new = KeyW'(in_count_i);
      dsvr_pkg::KeyOut: key_new = KeyW'(out_count_i);
      default:          key_new = KeyW'(out_count_i) + KeyW'(in_count_i);
    endcase
  end

  // group count and middle length of the warp interleave
  assign n_up  = (CntW+2)'(cnt_q) + (CntW+2)'(dsvr_pkg::GroupSize - 1);
  assign w_grp = CntW'(n_up >> 5);
  assign mid_n = cnt_q - (w_grp << 1);
  assign scat  = scatter_q && (cnt_q >= CntW'(2));

  assign issue_u = (state_q == dsvr_pkg::StSortU);
  assign last_u  = (u_q == cnt_q - CntW'(1));
  assign gt      = (key_b > key_a) || ((key_b == key_a) && (ud_q < v_q));

  // label index generator: ranks in order, or when interleaved head, tail, then middle slots
  always_comb begin
    emit     = 1'b0;
    rank_idx = pos_q;
    gi_d     = gi_q;
    sl_d     = sl_q;
    mo_d     = mo_q;
    if (state_q == dsvr_pkg::StLabel) begin
      if (!scat) begin
        emit = 1'b1;
      end else if (sl_q == dsvr_pkg::SlotHead) begin
        emit     = 1'b1;
        rank_idx = gi_q;
        sl_d     = dsvr_pkg::SlotTail;
      end else if (sl_q == dsvr_pkg::SlotTail) begin
        emit     = 1'b1;
        rank_idx = cnt_q - w_grp + gi_q;
        sl_d     = sl_q + dsvr_pkg::SlotW'(1);
      end else if (mo_q < mid_n) begin
        emit     = 1'b1;
        rank_idx = w_grp + mo_q;
        mo_d     = mo_q + CntW'(1);
        if (sl_q == dsvr_pkg::SlotMidLast) begin
          sl_d = dsvr_pkg::SlotHead;
          gi_d = gi_q + CntW'(1);
        end else begin
          sl_d = sl_q + dsvr_pkg::SlotW'(1);
        end
      end else begin
        sl_d = dsvr_pkg::SlotHead;
        gi_d = gi_q + CntW'(1);
      end
    end
  end
  assign last_emit = emit && (pos_q == cnt_q - CntW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsvr_pkg::StIdle:       if (vtx_fire && last_vertex_i) state_d = dsvr_pkg::StSortV;
      dsvr_pkg::StSortV:      state_d = dsvr_pkg::StSortU;
      dsvr_pkg::StSortU:      if (last_u) state_d = dsvr_pkg::StSortDrain;
      dsvr_pkg::StSortDrain:  state_d = dsvr_pkg::StSortWr;
      dsvr_pkg::StSortWr: begin
        if (v_q == cnt_q - CntW'(1)) state_d = dsvr_pkg::StLabel;
        else state_d = dsvr_pkg::StSortV;
      end
      dsvr_pkg::StLabel:      if (last_emit) state_d = dsvr_pkg::StLabelDrain;
      dsvr_pkg::StLabelDrain: state_d = dsvr_pkg::StIdle;
      default:                state_d = dsvr_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = (state_q == dsvr_pkg::StIdle) && !pend_q && !out_valid_q;
  end

  assign out_valid_o  = out_valid_q;
  assign new_src_o    = new_src_q;
  assign new_dst_o    = new_dst_q;
  assign bad_vertex_o = bad_q;

  // vertex count, labels-ready flag and counters of the sort sweep and label pass
  always_comb begin
    cnt_d   = cnt_q;
    ready_d = ready_q;
    v_d     = v_q;
    u_d     = u_q;
    r_d     = r_q;
    pos_d   = pos_q;
    if (vtx_fire) begin
      ready_d = 1'b0;
      cnt_d   = key_we ? cnt_eff + CntW'(1) : cnt_eff;
      v_d     = '0;
    end
    case (state_q)
      dsvr_pkg::StSortV: begin
        r_d = '0;
        u_d = '0;
      end
      dsvr_pkg::StSortU: u_d = u_q + CntW'(1);
      dsvr_pkg::StSortWr: begin
        v_d   = v_q + CntW'(1);
        pos_d = '0;
      end
      dsvr_pkg::StLabel: if (emit) pos_d = pos_q + CntW'(1);
      dsvr_pkg::StLabelDrain: ready_d = 1'b1;
      default: ;
    endcase
    if (p_q && gt) r_d = r_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsvr_pkg::StIdle;
      sort_key_q  <= dsvr_pkg::KeyIn;
      scatter_q   <= 1'b0;
      cnt_q       <= '0;
      ready_q     <= 1'b0;
      p_q         <= 1'b0;
      emit_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ready_q <= ready_d;
      p_q     <= issue_u;
      emit_q  <= emit;
      pend_q  <= edge_fire;
      if (cfg_we_i) begin
        case (dsvr_pkg::cfg_idx_e'(cfg_idx_i))
          dsvr_pkg::CfgSortKey: sort_key_q <= dsvr_pkg::sort_key_e'(cfg_data_i);
          dsvr_pkg::CfgScatter: scatter_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (pend_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    u_q   <= u_d;
    ud_q  <= u_q;
    r_q   <= r_d;
    pos_q <= pos_d;
    pd_q  <= pos_q;
    if (state_q == dsvr_pkg::StSortWr) begin
      gi_q <= '0;
      sl_q <= dsvr_pkg::SlotHead;
      mo_q <= '0;
    end else begin
      gi_q <= gi_d;
      sl_q <= sl_d;
      mo_q <= mo_d;
    end
    if (edge_fire) begin
      s_ok_q <= ready_q && (CntW'(src_id_i) < cnt_q);
      d_ok_q <= ready_q && (CntW'(dst_id_i) < cnt_q);
    end
    if (pend_q) begin
      new_src_q <= s_ok_q ? lab_s : '0;
      new_dst_q <= d_ok_q ? lab_d : '0;
      bad_q     <= !(s_ok_q && d_ok_q);
    end
  end

  // key memory: one write, two reads (vertex under rank, swept vertex)
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[cnt_eff[IdW-1:0]] <= key_new;
    key_a <= key_mem[v_q[IdW-1:0]];
    key_b <= key_mem[u_q[IdW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dsvr_pkg::StSortWr) rank_mem[r_q[IdW-1:0]] <= v_q[IdW-1:0];
    rank_rd <= rank_mem[rank_idx[IdW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (emit_q) label_mem[rank_rd] <= pd_q[IdW-1:0];
    lab_s <= label_mem[src_id_i];
    lab_d <= label_mem[dst_id_i];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == dsvr_pkg::StIdle))
    else $error("input taken while labeling");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> out_valid_o)
    else $error("edge lookup produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(state_q == dsvr_pkg::StLabelDrain))
    else $error("labels ready outside label pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("vertex count beyond store depth");

endmodule

### bench/degree_sort_vertex_relabel_checker.sv
`timescale 1ns / 100ps

module degree_sort_vertex_relabel_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsvr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dsvr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          kind_i,
  input  logic [dsvr_pkg::DegW-1:0]     out_count_i,
  input  logic [dsvr_pkg::DegW-1:0]     in_count_i,
  input  logic                          last_vertex_i,
  input  logic [dsvr_pkg::IdW-1:0]      src_id_i,
  input  logic [dsvr_pkg::IdW-1:0]      dst_id_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [dsvr_pkg::IdW-1:0]      new_src_i,
  input  logic [dsvr_pkg::IdW-1:0]      new_dst_i,
  input  logic                          bad_vertex_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int unsigned IdW         = dsvr_pkg::IdW;
  localparam int unsigned KeyW        = dsvr_pkg::KeyW;
  localparam int unsigned MaxVertices = dsvr_pkg::MaxVertices;
  localparam int unsigned GroupSize   = dsvr_pkg::GroupSize;
  localparam int unsigned MidPerGroup = dsvr_pkg::MidPerGroup;

  typedef struct packed {
    logic [IdW-1:0] new_src;
    logic [IdW-1:0] new_dst;
    logic           bad;
  } relabel_t;

  relabel_t        relabel_q[$];
  logic [KeyW-1:0] degree_key[MaxVertices];
  logic [IdW-1:0]  by_rank[MaxVertices];
  logic [IdW-1:0]  new_label[MaxVertices];
  int unsigned     loaded_n;
  logic            labeled;
  dsvr_pkg::sort_key_e key_sel;
  logic            scatter;

  task automatic build_labels();
    int unsigned n, r, w, mid, pos;
    n = loaded_n;
    if (n != 0) begin
      for (int unsigned v = 0; v < n; v++) begin
        r = 0;
        for (int unsigned u = 0; u < n; u++) begin
          if (degree_key[u] > degree_key[v] ||
              (degree_key[u] == degree_key[v] && u < v)) r++;
        end
        by_rank[r] = IdW'(v);
      end
      if (scatter && n >= 2) begin
        w   = (n + GroupSize - 1) / GroupSize;
        mid = n - 2 * w;
        pos = 0;
        for (int unsigned i = 0; i < w; i++) begin
          new_label[by_rank[i]] = IdW'(pos);
          pos++;
          new_label[by_rank[n - w + i]] = IdW'(pos);
          pos++;
          for (int unsigned j = 0; j < MidPerGroup && MidPerGroup * i + j < mid; j++) begin
            new_label[by_rank[w + MidPerGroup * i + j]] = IdW'(pos);
            pos++;
          end
        end
      end else begin
        for (int unsigned p = 0; p < n; p++) new_label[by_rank[p]] = IdW'(p);
      end
    end
    labeled = 1'b1;
  endtask

  task automatic take_beat();
    logic [KeyW-1:0] key;
    relabel_t        exp_r;
    if (kind_i == 1'b0) begin
      if (labeled) begin
        labeled  = 1'b0;
        loaded_n = 0;
      end
      case (key_sel)
        dsvr_pkg::KeyIn:  key = KeyW'(in_count_i);
        dsvr_pkg::KeyOut: key = KeyW'(out_count_i);
        default:          key = KeyW'(out_count_i) + KeyW'(in_count_i);
      endcase
      if (loaded_n < MaxVertices) begin
        degree_key[loaded_n] = key;
        loaded_n++;
      end
      if (last_vertex_i) build_labels();
    end else begin
      exp_r = '0;
      if (!labeled) begin
        exp_r.bad = 1'b1;
      end else begin
        if (src_id_i < loaded_n) exp_r.new_src = new_label[src_id_i];
        else exp_r.bad = 1'b1;
        if (dst_id_i < loaded_n) exp_r.new_dst = new_label[dst_id_i];
        else exp_r.bad = 1'b1;
      end
      relabel_q = {relabel_q, exp_r};
    end
  endtask

  task automatic check_result();
    relabel_t exp_r;
    if (relabel_q.size() == 0) begin
      $display("%0t: result beat with nothing expected: src %0d dst %0d bad %0b",
               $time, new_src_i, new_dst_i, bad_vertex_i);
      fail_count_o++;
    end else begin
      exp_r = relabel_q.pop_front();
      if (new_src_i !== exp_r.new_src) begin
        $display("%0t: new_src expected %0d actual %0d", $time, exp_r.new_src, new_src_i);
        fail_count_o++;
      end
      if (new_dst_i !== exp_r.new_dst) begin
        $display("%0t: new_dst expected %0d actual %0d", $time, exp_r.new_dst, new_dst_i);
        fail_count_o++;
      end
      if (bad_vertex_i !== exp_r.bad) begin
        $display("%0t: bad_vertex expected %0b actual %0b", $time, exp_r.bad, bad_vertex_i);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_n     = 0;
      labeled      = 1'b0;
      key_sel      = dsvr_pkg::KeyIn;
      scatter      = 1'b0;
      fail_count_o = 0;
      relabel_q.delete();
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == dsvr_pkg::CfgSortKey) key_sel = dsvr_pkg::sort_key_e'(cfg_data_i);
        else if (cfg_idx_i == dsvr_pkg::CfgScatter) scatter = cfg_data_i[0];
      end
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) take_beat();
      pending_o = relabel_q.size();
    end
  end
endmodule

### bench/degree_sort_vertex_relabel_tb.sv
`timescale 1ns / 100ps

module degree_sort_vertex_relabel_tb;

  localparam int unsigned IdW      = dsvr_pkg::IdW;
  localparam int unsigned DegW     = dsvr_pkg::DegW;
  localparam int unsigned CfgIdxW  = dsvr_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = dsvr_pkg::CfgDataW;

  localparam int unsigned StallLimit = 5_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = dsvr_pkg::CfgSortKey;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                kind = 1'b0;
  logic [DegW-1:0]     out_count = '0;
  logic [DegW-1:0]     in_count = '0;
  logic                last_vertex = 1'b0;
  logic [IdW-1:0]      src_id = '0;
  logic [IdW-1:0]      dst_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [IdW-1:0]      new_src;
  logic [IdW-1:0]      new_dst;
  logic                bad_vertex;
  int                  fail_count;
  int                  pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_request = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned beats_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  degree_sort_vertex_relabel DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .out_count_i(out_count), .in_count_i(in_count),
    .last_vertex_i(last_vertex), .src_id_i(src_id), .dst_id_i(dst_id),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .new_src_o(new_src), .new_dst_o(new_dst), .bad_vertex_o(bad_vertex)
  );

  degree_sort_vertex_relabel_checker relabel_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .out_count_i(out_count), .in_count_i(in_count),
    .last_vertex_i(last_vertex), .src_id_i(src_id), .dst_id_i(dst_id),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .new_src_i(new_src), .new_dst_i(new_dst), .bad_vertex_i(bad_vertex),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      out_ready = 1'b0;
      repeat (300) @(negedge clk);
      hold_request = 1'b0;
    end
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("degree_sort_vertex_relabel_tb: done, errors");
      $finish;
    end
  end

  task automatic send_beat(input logic k, input logic [DegW-1:0] oc, input logic [DegW-1:0] ic,
                           input logic lst, input logic [IdW-1:0] s, input logic [IdW-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    kind        = k;
    out_count   = oc;
    in_count    = ic;
    last_vertex = lst;
    src_id      = s;
    dst_id      = d;
    // ready comes from registers, so its value here holds through the next rising edge
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_vertex(input logic [DegW-1:0] oc, input logic [DegW-1:0] ic,
                             input logic lst);
    send_beat(1'b0, oc, ic, lst, IdW'($urandom), IdW'($urandom));
  endtask

  task automatic send_edge(input logic [IdW-1:0] s, input logic [IdW-1:0] d);
    send_beat(1'b1, DegW'($urandom), DegW'($urandom), 1'($urandom), s, d);
  endtask

  // an edge beat is only taken once labeling is over, so its result marks idle
  task automatic drain();
    send_edge(IdW'($urandom), IdW'($urandom));
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input dsvr_pkg::cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  function automatic logic [DegW-1:0] pick_degree();
    case ($urandom_range(3))
      0:       return DegW'($urandom);
      1:       return DegW'($urandom_range(7));
      2:       return '1;
      default: return DegW'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [IdW-1:0] pick_id(input int unsigned n);
    if (n > 0 && $urandom_range(9) < 8) return IdW'($urandom_range(n - 1));
    return IdW'($urandom);
  endfunction

  task automatic load_graph(input int unsigned n, input logic noisy);
    for (int unsigned v = 0; v < n; v++) begin
      if (noisy && $urandom_range(19) == 0) send_edge(IdW'($urandom), IdW'($urandom));
      send_vertex(pick_degree(), pick_degree(), v == n - 1);
    end
  endtask

  task automatic set_phase(input int unsigned p);
    case (p % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default: begin send_idle_pct = 7; recv_stall_pct = 7; end
    endcase
  endtask

  initial begin
    int unsigned n, graph_idx;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // edges before any labels exist
    send_edge('0, '0);
    send_edge('1, '1);
    // single vertex, extreme degrees
    send_vertex('1, '0, 1'b1);
    send_edge('0, '0);
    send_edge('0, 10'd1);
    send_edge('1, '0);
    drain();
    // key chosen at load time: first three vertices by out-degree, last two by in-degree
    write_reg(dsvr_pkg::CfgSortKey, dsvr_pkg::KeyOut);
    write_reg(dsvr_pkg::CfgScatter, 1'b1);
    send_vertex(16'd5, 16'd0, 1'b0);
    send_vertex(16'd5, '1, 1'b0);
    send_vertex('1, 16'd3, 1'b0);
    drain();
    write_reg(dsvr_pkg::CfgSortKey, dsvr_pkg::KeyIn);
    send_vertex(16'd9, 16'd5, 1'b0);
    send_vertex(16'd0, 16'd5, 1'b1);
    for (int unsigned i = 0; i < 6; i++) send_edge(IdW'(i), IdW'(5 - i));
    drain();
    // sum of two saturated degrees, ties broken by id
    write_reg(dsvr_pkg::CfgSortKey, dsvr_pkg::KeySum);
    send_vertex('1, '1, 1'b0);
    send_vertex('1, '1, 1'b0);
    send_vertex('0, '0, 1'b1);
    send_edge(10'd0, 10'd1);
    send_edge(10'd2, 10'd3);
    drain();

    graph_idx = 0;
    while (graph_idx < 4 || beats_sent < 1200 - 1060) begin
      set_phase(graph_idx);
      write_reg(dsvr_pkg::CfgSortKey, 2'($urandom));
      write_reg(dsvr_pkg::CfgScatter, 1'($urandom));
      n = ($urandom_range(7) == 0) ? $urandom_range(33, 80) : $urandom_range(1, 40);
      load_graph(n, 1'b1);
      if (graph_idx == 0) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
      end
      repeat ($urandom_range(10, 40)) send_edge(pick_id(n), pick_id(n));
      drain();
      graph_idx++;
    end

    // more vertices than the store holds
    set_phase(3);
    write_reg(dsvr_pkg::CfgSortKey, dsvr_pkg::KeySum);
    write_reg(dsvr_pkg::CfgScatter, 1'b1);
    load_graph(1030, 1'b0);
    repeat (30) send_edge(IdW'($urandom), IdW'($urandom));
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("degree_sort_vertex_relabel_tb: done, clean");
    end else begin
      $display("degree_sort_vertex_relabel_tb: done, errors");
    end
    $finish;
  end
endmodule
